// ===== hdl/pwbd_pkg.sv =====
// Shared types and constants for the pulse width bit decoder.
package pwbd_pkg;

  // Run counter width and limits.
  localparam int COUNT_WIDTH = 20;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  // Register widths and derived arithmetic widths.
  localparam int PERIOD_WIDTH = 20;
  localparam int LIMIT_WIDTH  = 24;
  localparam int DATA_WIDTH   = 24;
  localparam int INDEX_WIDTH  = 3;
  localparam int PROD_WIDTH   = COUNT_WIDTH + PERIOD_WIDTH;
  localparam int SUM_WIDTH    = PROD_WIDTH + 1;

  // Sample field.
  localparam int SAMPLE_WIDTH = 8;
  localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_LOW  = 8'd0;
  localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_HIGH = 8'd1;

  // Register indexes.
  localparam logic [INDEX_WIDTH-1:0] REG_SAMPLE_PERIOD = 3'd0;
  localparam logic [INDEX_WIDTH-1:0] REG_ZERO_PER_MIN  = 3'd1;
  localparam logic [INDEX_WIDTH-1:0] REG_ZERO_PER_MAX  = 3'd2;
  localparam logic [INDEX_WIDTH-1:0] REG_ZERO_DIFF_MAX = 3'd3;
  localparam logic [INDEX_WIDTH-1:0] REG_ONE_PER_MIN   = 3'd4;
  localparam logic [INDEX_WIDTH-1:0] REG_ONE_PER_MAX   = 3'd5;
  localparam logic [INDEX_WIDTH-1:0] REG_ONE_DIFF_MAX  = 3'd6;

  // Reset values of the registers.
  localparam logic [PERIOD_WIDTH-1:0] RST_SAMPLE_PERIOD = 20'd1000;
  localparam logic [LIMIT_WIDTH-1:0]  RST_ZERO_PER_MIN  = 24'd700000;
  localparam logic [LIMIT_WIDTH-1:0]  RST_ZERO_PER_MAX  = 24'd900000;
  localparam logic [LIMIT_WIDTH-1:0]  RST_ZERO_DIFF_MAX = 24'd200000;
  localparam logic [LIMIT_WIDTH-1:0]  RST_ONE_PER_MIN   = 24'd1100000;
  localparam logic [LIMIT_WIDTH-1:0]  RST_ONE_PER_MAX   = 24'd1300000;
  localparam logic [LIMIT_WIDTH-1:0]  RST_ONE_DIFF_MAX  = 24'd200000;

  // Queue between the counting front and the arithmetic back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
  localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

  // One closed period: the high and low run lengths in samples.
  typedef struct packed {
    logic [COUNT_WIDTH-1:0] high_run;
    logic [COUNT_WIDTH-1:0] low_run;
  } run_pair_t;

  // Current register set.
  typedef struct packed {
    logic [PERIOD_WIDTH-1:0] sample_period_ns;
    logic [LIMIT_WIDTH-1:0]  zero_period_min;
    logic [LIMIT_WIDTH-1:0]  zero_period_max;
    logic [LIMIT_WIDTH-1:0]  zero_diff_max;
    logic [LIMIT_WIDTH-1:0]  one_period_min;
    logic [LIMIT_WIDTH-1:0]  one_period_max;
    logic [LIMIT_WIDTH-1:0]  one_diff_max;
  } cfg_t;

endpackage

// ===== hdl/pulse_width_bit_decoder_top.sv =====
// Top level of the pulse width bit decoder: registers, front, queue and back.
//
// One sliced sample enters per input beat on sample with in_valid; in_stall
// low accepts it. Value 1 is a high sample, 0 a low one, anything else is
// ignored. A high sample that ends a high run followed by a low run closes a
// period; the back scales both runs by sample_period_ns and emits bit_res
// on the output channel (out_valid, out_stall) when the period falls in the
// bit zero or bit one window. Other periods produce no beat.
// Throughput is one sample per cycle while in_stall is low. A closing sample's
// result passes through the queue, the multiplier stage and the add and
// difference stage, and the window check loads the output register. When
// the receiver raises out_stall the back pipeline holds, the four-entry
// queue fills, and only then does in_stall rise; in_stall comes straight
// from the queue full flag. Reset clears the run counters, the queue, the
// pipeline and loads the default register values. Registers are written
// through cfg_we, cfg_index and cfg_data, only while the block is idle (a
// rule for the user, not enforced by the block); unknown indexes are ignored.
module pulse_width_bit_decoder_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [pwbd_pkg::SAMPLE_WIDTH-1:0] sample,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             bit_res,
  input  logic                             cfg_we,
  input  logic [pwbd_pkg::INDEX_WIDTH-1:0] cfg_index,
  input  logic [pwbd_pkg::DATA_WIDTH-1:0]  cfg_data
);
  import pwbd_pkg::*;

  cfg_t      cfg;
  logic      accept;
  logic      push;
  run_pair_t push_pair;
  logic      full;
  logic      head_valid;
  run_pair_t head_pair;
  logic      pop;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sample_period_ns <= RST_SAMPLE_PERIOD;
      cfg.zero_period_min  <= RST_ZERO_PER_MIN;
      cfg.zero_period_max  <= RST_ZERO_PER_MAX;
      cfg.zero_diff_max    <= RST_ZERO_DIFF_MAX;
      cfg.one_period_min   <= RST_ONE_PER_MIN;
      cfg.one_period_max   <= RST_ONE_PER_MAX;
      cfg.one_diff_max     <= RST_ONE_DIFF_MAX;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SAMPLE_PERIOD: cfg.sample_period_ns <= cfg_data[PERIOD_WIDTH-1:0];
        REG_ZERO_PER_MIN:  cfg.zero_period_min  <= cfg_data[LIMIT_WIDTH-1:0];
        REG_ZERO_PER_MAX:  cfg.zero_period_max  <= cfg_data[LIMIT_WIDTH-1:0];
        REG_ZERO_DIFF_MAX: cfg.zero_diff_max    <= cfg_data[LIMIT_WIDTH-1:0];
        REG_ONE_PER_MIN:   cfg.one_period_min   <= cfg_data[LIMIT_WIDTH-1:0];
        REG_ONE_PER_MAX:   cfg.one_period_max   <= cfg_data[LIMIT_WIDTH-1:0];
        REG_ONE_DIFF_MAX:  cfg.one_diff_max     <= cfg_data[LIMIT_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  pwbd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .sample    (sample),
    .push      (push),
    .push_pair (push_pair)
  );

  pwbd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_pair  (push_pair),
    .full       (full),
    .head_valid (head_valid),
    .head_pair  (head_pair),
    .pop        (pop)
  );

  pwbd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head_pair  (head_pair),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .bit_res    (bit_res)
  );

endmodule

// ===== hdl/pwbd_front.sv =====
// Front part: counts high and low runs and hands each closed period onward.
module pwbd_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              accept,
  input  logic [pwbd_pkg::SAMPLE_WIDTH-1:0] sample,
  output logic                              push,
  output pwbd_pkg::run_pair_t               push_pair
);
  import pwbd_pkg::*;

  logic [COUNT_WIDTH-1:0] high_run, high_run_next;
  logic [COUNT_WIDTH-1:0] low_run, low_run_next;
  logic                   closing;

  // A high sample with both runs nonzero closes one period.
  assign closing = accept && (sample == SAMPLE_HIGH) &&
                   (high_run != '0) && (low_run != '0);
  assign push = closing;
  assign push_pair.high_run = high_run;
  assign push_pair.low_run  = low_run;

  // Saturating run counters; low samples count only after a high one.
  always_comb begin
    high_run_next = high_run;
    low_run_next  = low_run;
    if (closing) begin
      high_run_next = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
      low_run_next  = '0;
    end else if (accept && (sample == SAMPLE_HIGH)) begin
      if (high_run != COUNT_MAX) high_run_next = high_run + 1'b1;
    end else if (accept && (sample == SAMPLE_LOW)) begin
      if ((high_run != '0) && (low_run != COUNT_MAX)) low_run_next = low_run + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      high_run <= '0;
      low_run  <= '0;
    end else begin
      high_run <= high_run_next;
      low_run  <= low_run_next;
    end
  end

endmodule

// ===== hdl/pwbd_queue.sv =====
// Short queue of closed periods between the front and the back.
module pwbd_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  pwbd_pkg::run_pair_t push_pair,
  output logic                full,
  output logic                head_valid,
  output pwbd_pkg::run_pair_t head_pair,
  input  logic                pop
);
  import pwbd_pkg::*;

  run_pair_t              entries [QUEUE_DEPTH];
  logic [QPTR_WIDTH-1:0]  wr_ptr;
  logic [QPTR_WIDTH-1:0]  rd_ptr;
  logic [QCNT_WIDTH-1:0]  count;
  logic                   do_pop;

  assign full       = (count == QCNT_WIDTH'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_pair  = entries[rd_ptr];
  assign do_pop     = pop && head_valid;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_pair;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/pwbd_back.sv =====
// Back part: scales the runs to nanoseconds, checks the windows, holds the result.
module pwbd_back (
  input  logic                clk,
  input  logic                rst,
  input  pwbd_pkg::cfg_t      cfg,
  input  logic                head_valid,
  input  pwbd_pkg::run_pair_t head_pair,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                bit_res
);
  import pwbd_pkg::*;

  logic                  v1, v2;
  logic [PROD_WIDTH-1:0] high_ns, low_ns;
  logic [SUM_WIDTH-1:0]  per_ns;
  logic [PROD_WIDTH-1:0] diff_ns;
  logic                  out_free, s2_free, s1_free;
  logic                  zero_hit, one_hit;

  // Each stage moves when the one after it is empty or moving.
  assign out_free = !out_valid || !out_stall;
  assign s2_free  = !v2 || out_free;
  assign s1_free  = !v1 || s2_free;
  assign pop      = head_valid && s1_free;

  // Stage one: run lengths times the sample period.
  always_ff @(posedge clk) begin
    if (s1_free) begin
      high_ns <= PROD_WIDTH'(head_pair.high_run) * PROD_WIDTH'(cfg.sample_period_ns);
      low_ns  <= PROD_WIDTH'(head_pair.low_run) * PROD_WIDTH'(cfg.sample_period_ns);
    end
  end

  // Stage two: full period and absolute high/low difference.
  always_ff @(posedge clk) begin
    if (s2_free) begin
      per_ns  <= SUM_WIDTH'(high_ns) + SUM_WIDTH'(low_ns);
      diff_ns <= (high_ns >= low_ns) ? (high_ns - low_ns) : (low_ns - high_ns);
    end
  end

  // Window checks; bit zero takes precedence.
  assign zero_hit = (per_ns >= SUM_WIDTH'(cfg.zero_period_min)) &&
                    (per_ns <= SUM_WIDTH'(cfg.zero_period_max)) &&
                    (diff_ns <= PROD_WIDTH'(cfg.zero_diff_max));
  assign one_hit  = (per_ns >= SUM_WIDTH'(cfg.one_period_min)) &&
                    (per_ns <= SUM_WIDTH'(cfg.one_period_max)) &&
                    (diff_ns <= PROD_WIDTH'(cfg.one_diff_max));

  // Output register; periods outside both windows leave no beat.
  always_ff @(posedge clk) begin
    if (out_free) bit_res <= !zero_hit;
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_free) v1 <= head_valid;
      if (s2_free) v2 <= v1;
      if (out_free) out_valid <= v2 && (zero_hit || one_hit);
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the pulse width bit decoder top level.
module testbench;
  import pwbd_pkg::*;

  localparam int CLK_HALF      = 10;
  localparam int RESET_CYCLES  = 11;
  localparam int MAX_IDLE      = 7;
  localparam int DRAIN_CYCLES  = 16;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int RAND_PHASES   = 8;
  localparam int PHASE_LEVELS  = 200;
  localparam int REPORT_CAP    = 40;
  localparam int CYCLE_LIMIT   = 4000000;

  // Index past the register list; writes to it must be ignored.
  localparam logic [INDEX_WIDTH-1:0] REG_PAST_END = 3'd7;
  localparam logic [DATA_WIDTH-1:0]  DATA_ALL     = '1;

  typedef enum logic {ROW_LEVEL, ROW_WRITE} row_kind_t;

  // One row of the directed stimulus: a run of samples or a register write.
  typedef struct packed {
    row_kind_t               kind;
    logic [SAMPLE_WIDTH-1:0] lvl;
    logic [7:0]              reps;
    logic [INDEX_WIDTH-1:0]  reg_idx;
    logic [DATA_WIDTH-1:0]   reg_val;
    logic                    typed;
    logic                    bit_due;
    logic                    bit_val;
  } stim_row_t;

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_stall;
  logic [SAMPLE_WIDTH-1:0] sample;
  logic                    out_valid;
  logic                    out_stall;
  logic                    bit_res;
  logic                    cfg_we;
  logic [INDEX_WIDTH-1:0]  cfg_index;
  logic [DATA_WIDTH-1:0]   cfg_data;

  // Decoder state mirrored by the testbench.
  cfg_t                   dec_cfg;
  logic [COUNT_WIDTH-1:0] run_high;
  logic [COUNT_WIDTH-1:0] run_low;
  logic                   bits_due[$];

  int unsigned mismatches  = 0;
  int unsigned cycle_cnt   = 0;
  int unsigned levels_sent = 0;
  bit          in_idle_on  = 1'b1;
  bit          out_idle_on = 1'b1;
  logic        want_bit;

  pulse_width_bit_decoder_top DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample    (sample),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .bit_res   (bit_res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  // Run-away guard.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("pulse_width_bit_decoder_top regression: fail");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= REPORT_CAP) $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
  endtask

  // Register update with masking to each register's width.
  function automatic void apply_reg(input logic [INDEX_WIDTH-1:0] idx,
                                    input logic [DATA_WIDTH-1:0] val);
    case (idx)
      REG_SAMPLE_PERIOD: dec_cfg.sample_period_ns = val[PERIOD_WIDTH-1:0];
      REG_ZERO_PER_MIN:  dec_cfg.zero_period_min  = val[LIMIT_WIDTH-1:0];
      REG_ZERO_PER_MAX:  dec_cfg.zero_period_max  = val[LIMIT_WIDTH-1:0];
      REG_ZERO_DIFF_MAX: dec_cfg.zero_diff_max    = val[LIMIT_WIDTH-1:0];
      REG_ONE_PER_MIN:   dec_cfg.one_period_min   = val[LIMIT_WIDTH-1:0];
      REG_ONE_PER_MAX:   dec_cfg.one_period_max   = val[LIMIT_WIDTH-1:0];
      REG_ONE_DIFF_MAX:  dec_cfg.one_diff_max     = val[LIMIT_WIDTH-1:0];
      default: ;
    endcase
  endfunction

  // Advances the run counters by one sample and reports a decoded bit, if any.
  function automatic logic decode_level(input logic [SAMPLE_WIDTH-1:0] lvl,
                                        output logic bit_out);
    logic [PROD_WIDTH-1:0] high_ns;
    logic [PROD_WIDTH-1:0] low_ns;
    logic [PROD_WIDTH-1:0] gap_ns;
    logic [SUM_WIDTH-1:0]  span_ns;
    logic                  hit;
    hit = 1'b0;
    bit_out = 1'b0;
    if (lvl == SAMPLE_HIGH) begin
      if (run_high != '0 && run_low != '0) begin
        high_ns = PROD_WIDTH'(run_high) * PROD_WIDTH'(dec_cfg.sample_period_ns);
        low_ns  = PROD_WIDTH'(run_low) * PROD_WIDTH'(dec_cfg.sample_period_ns);
        span_ns = SUM_WIDTH'(high_ns) + SUM_WIDTH'(low_ns);
        gap_ns  = (high_ns >= low_ns) ? high_ns - low_ns : low_ns - high_ns;
        // Bit zero is checked first and wins where the windows overlap.
        if (span_ns >= SUM_WIDTH'(dec_cfg.zero_period_min) &&
            span_ns <= SUM_WIDTH'(dec_cfg.zero_period_max) &&
            gap_ns <= PROD_WIDTH'(dec_cfg.zero_diff_max)) begin
          hit = 1'b1;
          bit_out = 1'b0;
        end else if (span_ns >= SUM_WIDTH'(dec_cfg.one_period_min) &&
                     span_ns <= SUM_WIDTH'(dec_cfg.one_period_max) &&
                     gap_ns <= PROD_WIDTH'(dec_cfg.one_diff_max)) begin
          hit = 1'b1;
          bit_out = 1'b1;
        end
        run_high = COUNT_WIDTH'(1);
        run_low  = '0;
      end else if (run_high != COUNT_MAX) begin
        run_high = run_high + 1'b1;
      end
    end else if (lvl == SAMPLE_LOW) begin
      if (run_high != '0 && run_low != COUNT_MAX) run_low = run_low + 1'b1;
    end
    return hit;
  endfunction

  function automatic logic [LIMIT_WIDTH-1:0] clamp_ns(input longint unsigned v);
    return (v > 64'hFF_FFFF) ? '1 : v[LIMIT_WIDTH-1:0];
  endfunction

  // Sends one sample beat; typed rows carry their own expectation.
  task automatic send_level(input logic [SAMPLE_WIDTH-1:0] lvl, input logic typed,
                            input logic due, input logic want);
    int unsigned gap;
    logic        got;
    logic        b;
    gap = in_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    sample   = lvl;
    do @(posedge clk); while (in_stall);
    got = decode_level(lvl, b);
    if (typed) begin
      if (due) bits_due.push_back(want);
    end else if (got) begin
      bits_due.push_back(b);
    end
    if (lvl == SAMPLE_LOW || lvl == SAMPLE_HIGH) levels_sent++;
    @(negedge clk);
  endtask

  // A run of equal samples, optionally sprinkled with ignored values.
  task automatic send_run(input logic [SAMPLE_WIDTH-1:0] lvl, input int unsigned n,
                          input bit noisy);
    repeat (n) begin
      if (noisy && $urandom_range(0, 19) == 0)
        send_level(SAMPLE_WIDTH'($urandom_range(2, 255)), 1'b0, 1'b0, 1'b0);
      send_level(lvl, 1'b0, 1'b0, 1'b0);
    end
  endtask

  task automatic write_reg(input logic [INDEX_WIDTH-1:0] idx,
                           input logic [DATA_WIDTH-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    apply_reg(idx, val);
  endtask

  // Waits until every expected bit is out and the pipeline has drained.
  task automatic settle();
    in_valid = 1'b0;
    while (bits_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Receiver: holds off a random number of cycles before taking each beat.
  initial begin
    int unsigned stall_n;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      stall_n = out_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (stall_n != 0) begin
        out_stall = 1'b1;
        repeat (stall_n) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid || rst);
      @(negedge clk);
    end
  end

  // Compares each accepted bit beat with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      if (bits_due.size() == 0) begin
        report_mismatch($sformatf("bit_res=%0b with no bit expected", bit_res));
      end else begin
        want_bit = bits_due.pop_front();
        if (bit_res !== want_bit)
          report_mismatch($sformatf("bit_res=%0b, expected %0b", bit_res, want_bit));
      end
    end
  end

  initial begin
    stim_row_t                dir_rows[$];
    stim_row_t                row;
    bit                       prev_write;
    int unsigned              ph;
    int unsigned              zs;
    int unsigned              os;
    int unsigned              tgt;
    int unsigned              hi;
    int unsigned              lo;
    int unsigned              kind;
    int unsigned              phase_end;
    int unsigned              waited;
    logic [PERIOD_WIDTH-1:0]  per_ns;
    logic [3:0]               pad;
    longint unsigned          p;

    rst       = 1'b1;
    in_valid  = 1'b0;
    sample    = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_SAMPLE_PERIOD;
    cfg_data  = '0;
    dec_cfg.sample_period_ns = RST_SAMPLE_PERIOD;
    dec_cfg.zero_period_min  = RST_ZERO_PER_MIN;
    dec_cfg.zero_period_max  = RST_ZERO_PER_MAX;
    dec_cfg.zero_diff_max    = RST_ZERO_DIFF_MAX;
    dec_cfg.one_period_min   = RST_ONE_PER_MIN;
    dec_cfg.one_period_max   = RST_ONE_PER_MAX;
    dec_cfg.one_diff_max     = RST_ONE_DIFF_MAX;
    run_high = '0;
    run_low  = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed cases: reset windows first, then short windows at 100 ns per sample.
    dir_rows = '{
      // Low before any high and a foreign value are both ignored.
      '{ROW_LEVEL, SAMPLE_LOW,  8'd1, REG_PAST_END, 24'd0, 1'b1, 1'b0, 1'b0},
      '{ROW_LEVEL, 8'hFF,       8'd1, REG_PAST_END, 24'd0, 1'b1, 1'b0, 1'b0},
      '{ROW_LEVEL, SAMPLE_HIGH, 8'd1, REG_PAST_END, 24'd0, 1'b1, 1'b0, 1'b0},
      '{ROW_LEVEL, SAMPLE_LOW,  8'd1, REG_PAST_END, 24'd0, 1'b1, 1'b0, 1'b0},
      // A 2000 ns period fits no window: nothing comes out.
      '{ROW_LEVEL, SAMPLE_HIGH, 8'd1, REG_PAST_END, 24'd0, 1'b1, 1'b0, 1'b0},
      '{ROW_WRITE, SAMPLE_LOW,  8'd0, REG_SAMPLE_PERIOD, 24'd100, 1'b0, 1'b0, 1'b0},
      '{ROW_WRITE, SAMPLE_LOW,  8'd0, REG_ZERO_PER_MIN,  24'd200, 1'b0, 1'b0, 1'b0},
      '{ROW_WRITE, SAMPLE_LOW,  8'd0, REG_ZERO_PER_MAX,  24'd200, 1'b0, 1'b0, 1'b0},
      '{ROW_WRITE, SAMPLE_LOW,  8'd0, REG_ZERO_DIFF_MAX, 24'd0,   1'b0, 1'b0, 1'b0},
      '{ROW_WRITE, SAMPLE_LOW,  8'd0, REG_ONE_PER_MIN,   24'd400, 1'b0, 1'b0, 1'b0},
      '{ROW_WRITE, SAMPLE_LOW,  8'd0, REG_ONE_PER_MAX,   24'd400, 1'b0, 1'b0, 1'b0},
      '{ROW_WRITE, SAMPLE_LOW,  8'd0, REG_ONE_DIFF_MAX,  24'd0,   1'b0, 1'b0, 1'b0},
      '{ROW_WRITE, SAMPLE_LOW,  8'd0, REG_PAST_END,      DATA_ALL, 1'b0, 1'b0, 1'b0},
      // One high and one low give bit zero, two and two give bit one.
      '{ROW_LEVEL, SAMPLE_LOW,  8'd1, REG_PAST_END, 24'd0, 1'b1, 1'b0, 1'b0},
      '{ROW_LEVEL, SAMPLE_HIGH, 8'd1, REG_PAST_END, 24'd0, 1'b1, 1'b1, 1'b0},
      '{ROW_LEVEL, SAMPLE_HIGH, 8'd1, REG_PAST_END, 24'd0, 1'b1, 1'b0, 1'b0},
      '{ROW_LEVEL, SAMPLE_LOW,  8'd2, REG_PAST_END, 24'd0, 1'b1, 1'b0, 1'b0},
      '{ROW_LEVEL, SAMPLE_HIGH, 8'd1, REG_PAST_END, 24'd0, 1'b1, 1'b1, 1'b1},
      '{ROW_LEVEL, 8'h02,       8'd1, REG_PAST_END, 24'd0, 1'b1, 1'b0, 1'b0},
      '{ROW_LEVEL, 8'h80,       8'd1, REG_PAST_END, 24'd0, 1'b1, 1'b0, 1'b0},
      // A 300 ns period lies between the windows.
      '{ROW_LEVEL, SAMPLE_LOW,  8'd2, REG_PAST_END, 24'd0, 1'b1, 1'b0, 1'b0},
      '{ROW_LEVEL, SAMPLE_HIGH, 8'd1, REG_PAST_END, 24'd0, 1'b1, 1'b0, 1'b0},
      // Overlapping windows: bit zero wins.
      '{ROW_WRITE, SAMPLE_LOW,  8'd0, REG_ONE_PER_MIN,   24'd200, 1'b0, 1'b0, 1'b0},
      '{ROW_LEVEL, SAMPLE_LOW,  8'd1, REG_PAST_END, 24'd0, 1'b1, 1'b0, 1'b0},
      '{ROW_LEVEL, SAMPLE_HIGH, 8'd1, REG_PAST_END, 24'd0, 1'b1, 1'b1, 1'b0},
      // Zero sample period: only a window that starts at 0 can match.
      '{ROW_WRITE, SAMPLE_LOW,  8'd0, REG_SAMPLE_PERIOD, 24'd0,   1'b0, 1'b0, 1'b0},
      '{ROW_LEVEL, SAMPLE_LOW,  8'd1, REG_PAST_END, 24'd0, 1'b1, 1'b0, 1'b0},
      '{ROW_LEVEL, SAMPLE_HIGH, 8'd1, REG_PAST_END, 24'd0, 1'b1, 1'b0, 1'b0},
      '{ROW_WRITE, SAMPLE_LOW,  8'd0, REG_ZERO_PER_MIN,  24'd0,   1'b0, 1'b0, 1'b0},
      '{ROW_LEVEL, SAMPLE_LOW,  8'd1, REG_PAST_END, 24'd0, 1'b1, 1'b0, 1'b0},
      '{ROW_LEVEL, SAMPLE_HIGH, 8'd1, REG_PAST_END, 24'd0, 1'b1, 1'b1, 1'b0},
      // All registers but the bit zero minimum at their largest values; the period write is masked.
      '{ROW_WRITE, SAMPLE_LOW,  8'd0, REG_SAMPLE_PERIOD, DATA_ALL, 1'b0, 1'b0, 1'b0},
      '{ROW_WRITE, SAMPLE_LOW,  8'd0, REG_ZERO_PER_MAX,  DATA_ALL, 1'b0, 1'b0, 1'b0},
      '{ROW_WRITE, SAMPLE_LOW,  8'd0, REG_ZERO_DIFF_MAX, DATA_ALL, 1'b0, 1'b0, 1'b0},
      '{ROW_WRITE, SAMPLE_LOW,  8'd0, REG_ONE_PER_MIN,   DATA_ALL, 1'b0, 1'b0, 1'b0},
      '{ROW_WRITE, SAMPLE_LOW,  8'd0, REG_ONE_PER_MAX,   DATA_ALL, 1'b0, 1'b0, 1'b0},
      '{ROW_WRITE, SAMPLE_LOW,  8'd0, REG_ONE_DIFF_MAX,  DATA_ALL, 1'b0, 1'b0, 1'b0},
      '{ROW_LEVEL, SAMPLE_LOW,  8'd1, REG_PAST_END, 24'd0, 1'b0, 1'b0, 1'b0},
      '{ROW_LEVEL, SAMPLE_HIGH, 8'd1, REG_PAST_END, 24'd0, 1'b0, 1'b0, 1'b0}
    };

    prev_write = 1'b0;
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.kind == ROW_WRITE) begin
        if (!prev_write) settle();
        write_reg(row.reg_idx, row.reg_val);
        prev_write = 1'b1;
      end else begin
        repeat (row.reps) send_level(row.lvl, row.typed, row.bit_due, row.bit_val);
        prev_write = 1'b0;
      end
    end

    // Random phases, each with its own windows and idling mix.
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      settle();
      in_idle_on  = ($urandom_range(0, 3) != 0);
      out_idle_on = ($urandom_range(0, 3) != 0);
      case (ph)
        0:       per_ns = '1;
        1:       per_ns = '0;
        2:       per_ns = PERIOD_WIDTH'(1);
        default: per_ns = PERIOD_WIDTH'($urandom_range(1, 5000));
      endcase
      pad = 4'($urandom_range(0, 15));
      write_reg(REG_SAMPLE_PERIOD, {pad, per_ns});
      zs = $urandom_range(2, 8);
      os = zs + $urandom_range(2, 6);
      p  = per_ns;
      if (ph % 4 == 3) begin
        write_reg(REG_ZERO_PER_MIN,  DATA_WIDTH'($urandom));
        write_reg(REG_ZERO_PER_MAX,  DATA_WIDTH'($urandom));
        write_reg(REG_ZERO_DIFF_MAX, DATA_WIDTH'($urandom));
        write_reg(REG_ONE_PER_MIN,   DATA_WIDTH'($urandom));
        write_reg(REG_ONE_PER_MAX,   DATA_WIDTH'($urandom));
        write_reg(REG_ONE_DIFF_MAX,  DATA_WIDTH'($urandom));
      end else begin
        // Windows one sample wide on each side of the nominal bit lengths.
        write_reg(REG_ZERO_PER_MIN,  clamp_ns(zs * p - p));
        write_reg(REG_ZERO_PER_MAX,  clamp_ns(zs * p + p));
        write_reg(REG_ZERO_DIFF_MAX, clamp_ns($urandom_range(0, 2) * p));
        write_reg(REG_ONE_PER_MIN,   clamp_ns(os * p - p));
        write_reg(REG_ONE_PER_MAX,   clamp_ns(os * p + p));
        write_reg(REG_ONE_DIFF_MAX,  clamp_ns($urandom_range(0, 2) * p));
      end

      phase_end = levels_sent + PHASE_LEVELS;
      while (levels_sent < phase_end) begin
        kind = $urandom_range(0, 15);
        tgt  = $urandom_range(0, 1) ? zs : os;
        hi   = tgt / 2 + $urandom_range(0, 2) - 1;
        lo   = tgt - tgt / 2 + $urandom_range(0, 2) - 1;
        if (hi == 0) hi = 1;
        if (lo == 0) lo = 1;
        if (kind <= 10) begin
          // Well-formed pulse near one of the bit lengths.
          send_run(SAMPLE_HIGH, hi, 1'b1);
          send_run(SAMPLE_LOW, lo, 1'b1);
        end else if (kind <= 12) begin
          send_run(SAMPLE_HIGH, $urandom_range(1, 20), 1'b1);
          send_run(SAMPLE_LOW, $urandom_range(1, 20), 1'b1);
        end else if (kind == 13) begin
          repeat ($urandom_range(1, 4))
            send_level(SAMPLE_WIDTH'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
        end else if (kind == 14) begin
          // Broken pulse: a short low run, then a short high run, sent without ignored values.
          send_run(SAMPLE_LOW, $urandom_range(1, 3), 1'b0);
          send_run(SAMPLE_HIGH, $urandom_range(1, 3), 1'b0);
        end else begin
          send_run(SAMPLE_HIGH, $urandom_range(30, 60), 1'b0);
        end
      end
    end

    // Drain and give a late stray beat time to show up.
    in_valid = 1'b0;
    waited = 0;
    while (bits_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (bits_due.size() != 0)
      report_mismatch($sformatf("%0d expected bits never arrived", bits_due.size()));
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0) begin
      $display("pulse_width_bit_decoder_top regression: pass");
    end else begin
      $display("pulse_width_bit_decoder_top regression: fail");
    end
    $finish;
  end

endmodule
